// ===== rtl/pic_pkg.sv =====
`default_nettype none

package pic_pkg;

  localparam int RANKED_SOURCES_DEF = 8;
  localparam logic [31:0] PRIO_RESET = 32'h00FA_C688;

  // queue between decode and execute; depth must be a power of two
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_LINE  = 2'd2;

  localparam logic [11:0] ADDR_PEND_LO  = 12'd0;
  localparam logic [11:0] ADDR_EN_LO    = 12'd4;
  localparam logic [11:0] ADDR_ROUTE_LO = 12'd8;
  localparam logic [11:0] ADDR_IRQ_LO   = 12'd12;
  localparam logic [11:0] ADDR_FIQ_LO   = 12'd16;
  localparam logic [11:0] ADDR_PRIO     = 12'd20;
  localparam logic [11:0] ADDR_IRQ_VEC  = 12'd24;
  localparam logic [11:0] ADDR_FIQ_VEC  = 12'd28;
  localparam logic [11:0] ADDR_PEND_HI  = 12'd32;
  localparam logic [11:0] ADDR_EN_HI    = 12'd36;
  localparam logic [11:0] ADDR_ROUTE_HI = 12'd40;
  localparam logic [11:0] ADDR_IRQ_HI   = 12'd44;
  localparam logic [11:0] ADDR_FIQ_HI   = 12'd48;
  localparam logic [11:0] ADDR_URGENT   = 12'd52;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_LINE  = 2'd2,
    OP_VOID  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    REG_PEND_LO  = 4'd0,
    REG_EN_LO    = 4'd1,
    REG_ROUTE_LO = 4'd2,
    REG_IRQ_LO   = 4'd3,
    REG_FIQ_LO   = 4'd4,
    REG_PRIO     = 4'd5,
    REG_IRQ_VEC  = 4'd6,
    REG_FIQ_VEC  = 4'd7,
    REG_PEND_HI  = 4'd8,
    REG_EN_HI    = 4'd9,
    REG_ROUTE_HI = 4'd10,
    REG_IRQ_HI   = 4'd11,
    REG_FIQ_HI   = 4'd12,
    REG_URGENT   = 4'd13
  } reg_sel_t;

  typedef struct packed {
    op_t         op;
    reg_sel_t    sel;
    logic [31:0] data;   // write data or line mask
    logic        bank;
    logic        level;
  } q_entry_t;

endpackage

`default_nettype wire

// ===== rtl/pic_in_if.sv =====
`default_nettype none

interface pic_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [11:0] address;
  logic [31:0] write_data;
  logic [31:0] line_mask;
  logic        line_bank;
  logic        line_level;

  modport source (
    output valid, command, address, write_data, line_mask, line_bank, line_level,
    input  ready
  );
  modport sink (
    input  valid, command, address, write_data, line_mask, line_bank, line_level,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/pic_out_if.sv =====
`default_nettype none

interface pic_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        access_ok;
  logic        irq_pending;
  logic        fiq_pending;

  modport source (
    output valid, read_data, access_ok, irq_pending, fiq_pending,
    input  ready
  );
  modport sink (
    input  valid, read_data, access_ok, irq_pending, fiq_pending,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/prioritized_interrupt_controller.sv =====
// Two-bank, 64-source interrupt controller driven by one item stream: each item is a
// register read, a register write or a source-line update, and each gives exactly one
// result (read data, decode status and the IRQ/FIQ pending flags after the item). A
// decode stage classifies the item and pushes it into a two-entry queue; an execute
// stage pops one item per cycle when its result register is free, updates the register
// file, computes the priority vectors and holds the result in an output register.
// Throughput is one item per clock while the result side keeps up; an accepted item
// is written to a queue slot and, once popped, its result is held in the output
// register. The execute stage's vector pick (urgent mask, ranked fields, lowest set
// bit) is the deepest path. RANKED_SOURCES selects how many low-bank sources use the
// 3-bit priority fields (1 to 10). No clearing pass is needed after reset.
`default_nettype none

module prioritized_interrupt_controller
  import pic_pkg::*;
#(
  parameter int RANKED_SOURCES = RANKED_SOURCES_DEF
) (
  input  wire       clk,
  input  wire       rst_n,
  pic_in_if.sink    in_ch,
  pic_out_if.source out_ch
);

  logic     push_valid, push_ready;
  q_entry_t push_data;
  logic     pop_valid, pop_ready;
  q_entry_t pop_data;

  // decode: map command and offset onto a queued operation
  pic_front u_front (
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // hold decoded items so decode and execute stall independently
  pic_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // execute: register file, vector pick and result register
  pic_back #(
    .RANKED_SOURCES (RANKED_SOURCES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

// ===== rtl/pic_front.sv =====
`default_nettype none

module pic_front
  import pic_pkg::*;
(
  pic_in_if.sink   in_ch,
  output logic     push_valid,
  input  logic     push_ready,
  output q_entry_t push_data
);

  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid;

  // classify: unmapped offsets and unused commands become void items
  always_comb begin
    push_data.op    = OP_VOID;
    push_data.sel   = REG_PEND_LO;
    push_data.data  = in_ch.write_data;
    push_data.bank  = in_ch.line_bank;
    push_data.level = in_ch.line_level;
    case (in_ch.command)
      CMD_READ: begin
        push_data.op = OP_READ;
        case (in_ch.address)
          ADDR_PEND_LO:  push_data.sel = REG_PEND_LO;
          ADDR_EN_LO:    push_data.sel = REG_EN_LO;
          ADDR_ROUTE_LO: push_data.sel = REG_ROUTE_LO;
          ADDR_IRQ_LO:   push_data.sel = REG_IRQ_LO;
          ADDR_FIQ_LO:   push_data.sel = REG_FIQ_LO;
          ADDR_PRIO:     push_data.sel = REG_PRIO;
          ADDR_IRQ_VEC:  push_data.sel = REG_IRQ_VEC;
          ADDR_FIQ_VEC:  push_data.sel = REG_FIQ_VEC;
          ADDR_PEND_HI:  push_data.sel = REG_PEND_HI;
          ADDR_EN_HI:    push_data.sel = REG_EN_HI;
          ADDR_ROUTE_HI: push_data.sel = REG_ROUTE_HI;
          ADDR_IRQ_HI:   push_data.sel = REG_IRQ_HI;
          ADDR_FIQ_HI:   push_data.sel = REG_FIQ_HI;
          ADDR_URGENT:   push_data.sel = REG_URGENT;
          default:       push_data.op  = OP_VOID;
        endcase
      end
      CMD_WRITE: begin
        push_data.op = OP_WRITE;
        case (in_ch.address)
          ADDR_EN_LO:    push_data.sel = REG_EN_LO;
          ADDR_ROUTE_LO: push_data.sel = REG_ROUTE_LO;
          ADDR_PRIO:     push_data.sel = REG_PRIO;
          ADDR_EN_HI:    push_data.sel = REG_EN_HI;
          ADDR_ROUTE_HI: push_data.sel = REG_ROUTE_HI;
          ADDR_URGENT:   push_data.sel = REG_URGENT;
          default:       push_data.op  = OP_VOID;
        endcase
      end
      CMD_LINE: begin
        push_data.op   = OP_LINE;
        push_data.data = in_ch.line_mask;
      end
      default: push_data.op = OP_VOID;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/pic_queue.sv =====
`default_nettype none

module pic_queue
  import pic_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  output logic     push_ready,
  input  q_entry_t push_data,
  output logic     pop_valid,
  input  logic     pop_ready,
  output q_entry_t pop_data
);

  q_entry_t             slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   count_r, count_nxt;
  logic                 push, pop;

  assign push_ready = (count_r != Q_CNT_W'(Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pic_back.sv =====
`default_nettype none

module pic_back
  import pic_pkg::*;
#(
  parameter int RANKED_SOURCES = RANKED_SOURCES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      pop_valid,
  output logic      pop_ready,
  input  q_entry_t  pop_data,
  pic_out_if.source out_ch
);

  localparam logic [31:0] RANK_MASK = 32'((64'd1 << RANKED_SOURCES) - 64'd1);

  logic [31:0] pend_lo_r, pend_lo_nxt, en_lo_r, en_lo_nxt, route_lo_r, route_lo_nxt;
  logic [31:0] pend_hi_r, pend_hi_nxt, en_hi_r, en_hi_nxt, route_hi_r, route_hi_nxt;
  logic [31:0] prio_r, prio_nxt, urgent_r, urgent_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [31:0] rdata_r, rdata_nxt;
  logic        ok_r, ok_nxt, irq_r, irq_nxt, fiq_r, fiq_nxt;

  logic        take;
  logic [31:0] irq_lo, fiq_lo, irq_hi, fiq_hi;
  logic [31:0] irq_vec, fiq_vec;

  function automatic logic [4:0] lowest_bit(input logic [31:0] v);
    logic [4:0] r;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      if (v[i]) r = 5'(i);
    end
    return r;
  endfunction

  // urgent high-bank sources, then ranked sources, then low bank, then high bank
  function automatic logic [5:0] pick_index(input logic [31:0] s, input logic [31:0] s2,
                                            input logic [31:0] prio,
                                            input logic [31:0] urgent);
    logic [31:0] urg;
    logic [4:0]  best;
    logic [3:0]  best_p;
    logic [5:0]  idx;
    urg    = s2 & urgent;
    best   = '0;
    best_p = 4'd8;
    for (int i = 0; i < RANKED_SOURCES; i++) begin
      if (s[i] && ({1'b0, prio[3*i +: 3]} < best_p)) begin
        best_p = {1'b0, prio[3*i +: 3]};
        best   = 5'(i);
      end
    end
    if (urg != '0) begin
      idx = {1'b1, lowest_bit(urg)};
    end else if ((s & RANK_MASK) != '0) begin
      idx = {1'b0, best};
    end else if (s != '0) begin
      idx = {1'b0, lowest_bit(s)};
    end else begin
      idx = {1'b1, lowest_bit(s2)};
    end
    return idx;
  endfunction

  function automatic logic [31:0] vector_of(input logic [31:0] s, input logic [31:0] s2,
                                            input logic [31:0] prio,
                                            input logic [31:0] urgent);
    logic [8:0] v;
    v = ({3'b000, pick_index(s, s2, prio, urgent)} + 9'd1) << 2;
    return ((s | s2) == '0) ? 32'd0 : {23'd0, v};
  endfunction

  assign pop_ready = !out_valid_r || out_ch.ready;
  assign take      = pop_valid && pop_ready;

  assign irq_lo  = pend_lo_r & en_lo_r & ~route_lo_r;
  assign fiq_lo  = pend_lo_r & en_lo_r & route_lo_r;
  assign irq_hi  = pend_hi_r & en_hi_r & ~route_hi_r;
  assign fiq_hi  = pend_hi_r & en_hi_r & route_hi_r;
  assign irq_vec = vector_of(irq_lo, irq_hi, prio_r, urgent_r);
  assign fiq_vec = vector_of(fiq_lo, fiq_hi, prio_r, urgent_r);

  always_comb begin
    pend_lo_nxt  = pend_lo_r;
    en_lo_nxt    = en_lo_r;
    route_lo_nxt = route_lo_r;
    pend_hi_nxt  = pend_hi_r;
    en_hi_nxt    = en_hi_r;
    route_hi_nxt = route_hi_r;
    prio_nxt     = prio_r;
    urgent_nxt   = urgent_r;
    rdata_nxt    = rdata_r;
    ok_nxt       = ok_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    if (take) begin
      out_valid_nxt = 1'b1;
      rdata_nxt     = '0;
      ok_nxt        = 1'b1;
      case (pop_data.op)
        OP_READ: begin
          case (pop_data.sel)
            REG_PEND_LO:  rdata_nxt = pend_lo_r;
            REG_EN_LO:    rdata_nxt = en_lo_r;
            REG_ROUTE_LO: rdata_nxt = route_lo_r;
            REG_IRQ_LO:   rdata_nxt = irq_lo;
            REG_FIQ_LO:   rdata_nxt = fiq_lo;
            REG_PRIO:     rdata_nxt = prio_r;
            REG_IRQ_VEC:  rdata_nxt = irq_vec;
            REG_FIQ_VEC:  rdata_nxt = fiq_vec;
            REG_PEND_HI:  rdata_nxt = pend_hi_r;
            REG_EN_HI:    rdata_nxt = en_hi_r;
            REG_ROUTE_HI: rdata_nxt = route_hi_r;
            REG_IRQ_HI:   rdata_nxt = irq_hi;
            REG_FIQ_HI:   rdata_nxt = fiq_hi;
            REG_URGENT:   rdata_nxt = urgent_r;
            default:      ok_nxt    = 1'b0;
          endcase
        end
        OP_WRITE: begin
          case (pop_data.sel)
            REG_EN_LO:    en_lo_nxt    = pop_data.data;
            REG_ROUTE_LO: route_lo_nxt = pop_data.data;
            REG_PRIO:     prio_nxt     = pop_data.data;
            REG_EN_HI:    en_hi_nxt    = pop_data.data;
            REG_ROUTE_HI: route_hi_nxt = pop_data.data;
            REG_URGENT:   urgent_nxt   = pop_data.data;
            default:      ok_nxt       = 1'b0;
          endcase
        end
        OP_LINE: begin
          if (pop_data.bank) begin
            pend_hi_nxt = pop_data.level ? (pend_hi_r | pop_data.data)
                                         : (pend_hi_r & ~pop_data.data);
          end else begin
            pend_lo_nxt = pop_data.level ? (pend_lo_r | pop_data.data)
                                         : (pend_lo_r & ~pop_data.data);
          end
        end
        default: ok_nxt = 1'b0;
      endcase
    end

    // pending flags reflect the state left behind by this item
    irq_nxt = irq_r;
    fiq_nxt = fiq_r;
    if (take) begin
      irq_nxt = |((pend_lo_nxt & en_lo_nxt & ~route_lo_nxt) |
                  (pend_hi_nxt & en_hi_nxt & ~route_hi_nxt));
      fiq_nxt = |((pend_lo_nxt & en_lo_nxt & route_lo_nxt) |
                  (pend_hi_nxt & en_hi_nxt & route_hi_nxt));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_lo_r   <= '0;
      en_lo_r     <= '0;
      route_lo_r  <= '0;
      pend_hi_r   <= '0;
      en_hi_r     <= '0;
      route_hi_r  <= '0;
      prio_r      <= PRIO_RESET;
      urgent_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_lo_r   <= pend_lo_nxt;
      en_lo_r     <= en_lo_nxt;
      route_lo_r  <= route_lo_nxt;
      pend_hi_r   <= pend_hi_nxt;
      en_hi_r     <= en_hi_nxt;
      route_hi_r  <= route_hi_nxt;
      prio_r      <= prio_nxt;
      urgent_r    <= urgent_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= rdata_nxt;
    ok_r    <= ok_nxt;
    irq_r   <= irq_nxt;
    fiq_r   <= fiq_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.read_data   = rdata_r;
  assign out_ch.access_ok   = ok_r;
  assign out_ch.irq_pending = irq_r;
  assign out_ch.fiq_pending = fiq_r;

endmodule

`default_nettype wire
